### hw/rtl/xcsh_pkg.sv
// ----------------------------------------------------------------------------
// xcsh_pkg
// Shared types, command codes and constant tables of the XCP slave command
// handler.
// ----------------------------------------------------------------------------
`default_nettype none

package xcsh_pkg;

    // default size of the target memory in bytes
    localparam int MEM_BYTES_DEF = 65536;

    // packet identifiers and error code
    localparam logic [7:0] PID_OK     = 8'hFF;
    localparam logic [7:0] PID_ERR    = 8'hFE;
    localparam logic [7:0] ERR_SYNTAX = 8'h20;

    // command codes
    localparam logic [7:0] CMD_CONNECT      = 8'hFF;
    localparam logic [7:0] CMD_DISCONNECT   = 8'hFE;
    localparam logic [7:0] CMD_GET_STATUS   = 8'hFD;
    localparam logic [7:0] CMD_SYNCH        = 8'hFC;
    localparam logic [7:0] CMD_GET_ID       = 8'hFA;
    localparam logic [7:0] CMD_SET_MTA      = 8'hF6;
    localparam logic [7:0] CMD_UPLOAD       = 8'hF5;
    localparam logic [7:0] CMD_SHORT_UPLOAD = 8'hF4;
    localparam logic [7:0] CMD_DOWNLOAD     = 8'hF0;

    // configuration register indexes
    localparam logic [1:0] CFG_SESSION_STATUS  = 2'd0;
    localparam logic [1:0] CFG_PROTECTION_MASK = 2'd1;
    localparam logic [1:0] CFG_SESSION_NUMBER  = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_COPY,
        S_EMIT
    } state_t;

    // kind of response being streamed
    typedef enum logic [2:0] {
        R_OK,
        R_ERR,
        R_CONNECT,
        R_STATUS,
        R_ID,
        R_UPLOAD
    } resp_kind_t;

    // controller to datapath
    typedef struct packed {
        logic init_en;
        logic rx_en;
        logic decode;
        logic copy_en;
        logic emit_en;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_last;
        logic copy_go;
        logic copy_last;
        logic emit_last;
    } dp_status_t;

    // fixed identification text
    function automatic logic [7:0] id_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "D";
            4'd1:    c = "E";
            4'd2:    c = "M";
            4'd3:    c = "O";
            4'd4:    c = "_";
            4'd5:    c = "X";
            4'd6:    c = "C";
            4'd7:    c = "P";
            4'd8:    c = "_";
            4'd9:    c = "U";
            4'd10:   c = "D";
            4'd11:   c = "P";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/xcsh_ctrl.sv
// ----------------------------------------------------------------------------
// xcsh_ctrl
// Controller state machine: memory clear pass, packet reception, decode,
// download copy and response streaming.
// ----------------------------------------------------------------------------
`default_nettype none

module xcsh_ctrl
    import xcsh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       req_last,
    input  wire dp_status_t st,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (st.init_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start && req_last)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = st.copy_go ? S_COPY : S_EMIT;
            end
            S_COPY:
            begin
                if (st.copy_last)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.emit_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_INIT:   cmd.init_en = 1'b1;
            S_IDLE:   cmd.rx_en   = 1'b1;
            S_DECODE: cmd.decode  = 1'b1;
            S_COPY:   cmd.copy_en = 1'b1;
            S_EMIT:   cmd.emit_en = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/xcsh_dp.sv
// ----------------------------------------------------------------------------
// xcsh_dp
// Datapath: configuration registers, packet header and download buffers,
// target memory, transfer pointer, command decode and response word packer.
// ----------------------------------------------------------------------------
`default_nettype none

module xcsh_dp
    import xcsh_pkg::*;
#(
    parameter int MEMORY_BYTES = MEM_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctrl_cmd_t   cmd,
    output dp_status_t       st,
    input  wire logic        start,
    input  wire logic [7:0]  req_byte,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             resp_valid,
    output logic [63:0]      resp_word,
    output logic [3:0]       resp_count,
    output logic             resp_last
);

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] MB_P   = PW'(MEMORY_BYTES);
    localparam logic [AW-1:0] LAST_A = AW'(MEMORY_BYTES - 1);
    localparam logic [31:0]   MB_32  = 32'(MEMORY_BYTES);

    // configuration
    logic [7:0]  status_reg;
    logic [7:0]  mask_reg;
    logic [15:0] session_reg;

    // reception
    logic [8:0]  pos_reg;
    logic [7:0]  hdr_reg [8];
    logic [7:0]  dl_reg [255];
    logic        accept;

    // memory and pointer
    logic [7:0]    tmem_reg [MEMORY_BYTES];
    logic [AW-1:0] init_cnt_reg;
    logic [PW-1:0] ptr_reg;
    logic [AW-1:0] base_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] rd_addr;
    logic [8:0]    rd_off;
    logic [7:0]    mem_rdata_reg;
    logic [7:0]    init_byte;
    logic [31:0]   init_a32;

    // download copy
    logic [7:0] cp_n_reg;
    logic [7:0] cp_reg;
    logic [7:0] cp_d_reg;
    logic       cpv_d_reg;
    logic [7:0] dl_rdata_reg;
    logic       cp_issue;

    // response stream
    resp_kind_t kind_reg;
    logic [8:0] len_reg;
    logic [8:0] j_reg;
    logic [8:0] j_d_reg;
    logic       jv_d_reg;
    logic       j_issue;
    logic [7:0] push_byte;
    logic [3:0] jl;

    // packer
    logic [63:0] pk_word_reg;
    logic [2:0]  pk_cnt_reg;
    logic [63:0] merged;

    // decode results
    resp_kind_t    dec_kind;
    logic [8:0]    dec_len;
    logic [7:0]    dec_n;
    logic [AW-1:0] dec_base;
    logic [PW-1:0] dec_ptr;
    logic          dec_copy;
    logic [31:0]   a_mta;
    logic [31:0]   a_short;
    logic [AW-1:0] mta_c;
    logic [AW-1:0] short_c;
    logic [PW-1:0] room_ptr;
    logic [PW-1:0] room_short;
    logic [PW-1:0] n_up;
    logic [PW-1:0] n_dl;
    logic [PW-1:0] n_sh;
    logic [7:0]    n8;

    assign accept = start && cmd.rx_en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= 8'd0;
            mask_reg    <= 8'd0;
            session_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SESSION_STATUS)
                status_reg <= cfg_data[7:0];
            if (cfg_index == CFG_PROTECTION_MASK)
                mask_reg <= cfg_data[7:0];
            if (cfg_index == CFG_SESSION_NUMBER)
                session_reg <= cfg_data;
        end
    end

    // byte count and header capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 9'd0;
            for (int i = 0; i < 8; i++)
                hdr_reg[i] <= 8'd0;
        end
        else if (cmd.decode)
        begin
            pos_reg <= 9'd0;
        end
        else if (accept)
        begin
            if (pos_reg < 9'd8)
                hdr_reg[pos_reg[2:0]] <= req_byte;
            if (pos_reg != 9'd511)
                pos_reg <= pos_reg + 9'd1;
        end
    end

    // download buffer
    always_ff @(posedge clk)
    begin
        if (accept && pos_reg >= 9'd2 && pos_reg < 9'd257)
            dl_reg[8'(pos_reg - 9'd2)] <= req_byte;
        dl_rdata_reg <= dl_reg[cp_reg];
    end

    // decode
    assign n8       = hdr_reg[1];
    assign a_mta    = {hdr_reg[5], hdr_reg[4], hdr_reg[3], hdr_reg[2]};
    assign a_short  = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
    assign mta_c    = (a_mta >= MB_32) ? LAST_A : AW'(a_mta);
    assign short_c  = (a_short >= MB_32) ? LAST_A : AW'(a_short);
    assign room_ptr   = MB_P - ptr_reg;
    assign room_short = MB_P - PW'(short_c);

    always_comb
    begin
        logic [PW-1:0] nu;
        nu = (n8 == 8'd0) ? PW'(1) : PW'(n8);
        n_up = (nu > room_ptr) ? room_ptr : nu;
        n_dl = (PW'(n8) > room_ptr) ? room_ptr : PW'(n8);
        n_sh = (PW'(n8) > room_short) ? room_short : PW'(n8);
    end

    always_comb
    begin
        dec_kind = R_ERR;
        dec_len  = 9'd2;
        dec_n    = 8'd0;
        dec_base = ptr_reg[AW-1:0];
        dec_ptr  = ptr_reg;
        dec_copy = 1'b0;
        unique case (hdr_reg[0])
            CMD_CONNECT:
            begin
                dec_kind = R_CONNECT;
                dec_len  = 9'd8;
            end
            CMD_GET_STATUS:
            begin
                dec_kind = R_STATUS;
                dec_len  = 9'd8;
            end
            CMD_GET_ID:
            begin
                dec_kind = R_ID;
                dec_len  = 9'd15;
            end
            CMD_SET_MTA:
            begin
                if (pos_reg >= 9'd6)
                begin
                    dec_kind = R_OK;
                    dec_len  = 9'd1;
                    dec_ptr  = PW'(mta_c);
                end
            end
            CMD_UPLOAD:
            begin
                if (pos_reg >= 9'd2)
                begin
                    dec_kind = R_UPLOAD;
                    dec_len  = 9'd1 + 9'(n_up);
                    dec_ptr  = ptr_reg + n_up;
                end
            end
            CMD_SHORT_UPLOAD:
            begin
                if (pos_reg >= 9'd8)
                begin
                    dec_kind = R_UPLOAD;
                    dec_len  = 9'd1 + 9'(n_sh);
                    dec_base = short_c;
                end
            end
            CMD_DOWNLOAD:
            begin
                if (pos_reg >= 9'd2 && {1'b0, pos_reg} >= 10'd2 + 10'(n8))
                begin
                    dec_kind = R_OK;
                    dec_len  = 9'd1;
                    dec_n    = 8'(n_dl);
                    dec_ptr  = ptr_reg + n_dl;
                    dec_copy = (n_dl != '0);
                end
            end
            CMD_DISCONNECT, CMD_SYNCH:
            begin
                dec_kind = R_OK;
                dec_len  = 9'd1;
            end
            default:
            begin
                dec_kind = R_ERR;
            end
        endcase
    end

    // pointer and decode registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            kind_reg <= R_OK;
            len_reg  <= 9'd1;
            cp_n_reg <= 8'd0;
            base_reg <= '0;
        end
        else if (cmd.decode)
        begin
            ptr_reg  <= dec_ptr;
            kind_reg <= dec_kind;
            len_reg  <= dec_len;
            cp_n_reg <= dec_n;
            base_reg <= dec_base;
        end
    end

    // clear pass pattern
    assign init_a32  = 32'(init_cnt_reg);
    always_comb
    begin
        init_byte = init_cnt_reg[7:0];
        if (MEMORY_BYTES > 32'h1003)
        begin
            if (init_a32 == 32'h1000) init_byte = 8'h11;
            if (init_a32 == 32'h1001) init_byte = 8'h22;
            if (init_a32 == 32'h1002) init_byte = 8'h33;
            if (init_a32 == 32'h1003) init_byte = 8'h44;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_cnt_reg <= '0;
        else if (cmd.init_en)
            init_cnt_reg <= init_cnt_reg + AW'(1);
    end

    // target memory port
    assign rd_off    = j_reg - 9'd1;
    assign rd_addr   = base_reg + AW'(rd_off);
    assign mem_we    = cmd.init_en || cpv_d_reg;
    assign mem_waddr = cmd.init_en ? init_cnt_reg : base_reg + AW'(cp_d_reg);
    assign mem_wdata = cmd.init_en ? init_byte : dl_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tmem_reg[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= tmem_reg[rd_addr];
    end

    // download copy sequencing
    assign cp_issue = cmd.copy_en && (cp_reg < cp_n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg    <= 8'd0;
            cp_d_reg  <= 8'd0;
            cpv_d_reg <= 1'b0;
        end
        else
        begin
            cpv_d_reg <= cp_issue;
            cp_d_reg  <= cp_reg;
            if (cmd.decode)
                cp_reg <= 8'd0;
            else if (cp_issue)
                cp_reg <= cp_reg + 8'd1;
        end
    end

    // response byte sequencing
    assign j_issue = cmd.emit_en && (j_reg < len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg    <= 9'd0;
            j_d_reg  <= 9'd0;
            jv_d_reg <= 1'b0;
        end
        else
        begin
            jv_d_reg <= j_issue;
            j_d_reg  <= j_reg;
            if (cmd.decode)
                j_reg <= 9'd0;
            else if (j_issue)
                j_reg <= j_reg + 9'd1;
        end
    end

    // response byte select
    assign jl = j_d_reg[3:0];
    always_comb
    begin
        push_byte = 8'h00;
        if (j_d_reg == 9'd0)
        begin
            push_byte = (kind_reg == R_ERR) ? PID_ERR : PID_OK;
        end
        else
        begin
            unique case (kind_reg)
                R_ERR:     push_byte = ERR_SYNTAX;
                R_UPLOAD:  push_byte = mem_rdata_reg;
                R_CONNECT:
                begin
                    unique case (jl)
                        4'd1:    push_byte = 8'h04;
                        4'd2:    push_byte = 8'h80;
                        4'd3:    push_byte = 8'h20;
                        4'd4:    push_byte = 8'h20;
                        4'd6:    push_byte = 8'h01;
                        4'd7:    push_byte = 8'h01;
                        default: push_byte = 8'h00;
                    endcase
                end
                R_STATUS:
                begin
                    unique case (jl)
                        4'd1:    push_byte = status_reg;
                        4'd2:    push_byte = mask_reg;
                        4'd4:    push_byte = session_reg[7:0];
                        4'd5:    push_byte = session_reg[15:8];
                        default: push_byte = 8'h00;
                    endcase
                end
                R_ID:
                begin
                    if (jl == 4'd2)
                        push_byte = 8'd12;
                    else if (jl >= 4'd3)
                        push_byte = id_char(jl - 4'd3);
                    else
                        push_byte = 8'h00;
                end
                default:   push_byte = 8'h00;
            endcase
        end
    end

    // status to controller
    assign st.init_last = cmd.init_en && (init_cnt_reg == LAST_A);
    assign st.copy_go   = dec_copy;
    assign st.copy_last = cpv_d_reg && (cp_d_reg == cp_n_reg - 8'd1);
    assign st.emit_last = jv_d_reg && (j_d_reg == len_reg - 9'd1);

    // word packer and output register
    assign merged = pk_word_reg | (64'(push_byte) << {pk_cnt_reg, 3'b000});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_cnt_reg  <= 3'd0;
            pk_word_reg <= 64'd0;
            resp_valid  <= 1'b0;
        end
        else
        begin
            resp_valid <= 1'b0;
            if (jv_d_reg)
            begin
                if (pk_cnt_reg == 3'd7 || st.emit_last)
                begin
                    resp_valid  <= 1'b1;
                    pk_cnt_reg  <= 3'd0;
                    pk_word_reg <= 64'd0;
                end
                else
                begin
                    pk_cnt_reg  <= pk_cnt_reg + 3'd1;
                    pk_word_reg <= merged;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (jv_d_reg && (pk_cnt_reg == 3'd7 || st.emit_last))
        begin
            resp_word  <= merged;
            resp_count <= {1'b0, pk_cnt_reg} + 4'd1;
            resp_last  <= st.emit_last;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/xcp_slave_command_handler.sv
// ----------------------------------------------------------------------------
// xcp_slave_command_handler
// Byte-wise XCP request receiver with command decode, target memory access
// and response words of up to eight bytes.
// ----------------------------------------------------------------------------
// Reset: a clear pass writes the demo pattern into the target memory, one byte
//   a cycle; busy stays high until it ends.
// Request bytes are taken one per cycle while busy is low.
// After the last byte: a decode state, for DOWNLOAD a copy of its data bytes
//   through the single memory write port, then the L-byte response is streamed
//   (one byte a cycle, a word strobe every eight bytes and at the end).
// Result words cannot be stalled by the receiver.
`default_nettype none

module xcp_slave_command_handler
    import xcsh_pkg::*;
#(
    parameter int MEMORY_BYTES = MEM_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  req_byte,
    input  wire logic        req_last,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             resp_valid,
    output logic [63:0]      resp_word,
    output logic [3:0]       resp_count,
    output logic             resp_last
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // control
    xcsh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_last (req_last),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    xcsh_dp #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .start      (start),
        .req_byte   (req_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .resp_valid (resp_valid),
        .resp_word  (resp_word),
        .resp_count (resp_count),
        .resp_last  (resp_last)
    );

    assign busy = !cmd.rx_en;

endmodule

`default_nettype wire

### hw/rtl/xcsh_checker.sv
// ----------------------------------------------------------------------------
// xcsh_checker
// Port-level checks of the command handler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xcsh_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        req_last,
    input wire logic        resp_valid,
    input wire logic [3:0]  resp_count,
    input wire logic        resp_last
);

    // word count in range
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> (resp_count != 4'd0 && resp_count <= 4'd8))
        else $error("response word count out of range");

    // only the final word may be partial
    a_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && resp_count != 4'd8) |-> resp_last)
        else $error("partial word before end of response");

    // packet end starts processing
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_last) |=> busy)
        else $error("handler not busy after last request word");

    // more words follow: still busy or the final word is out
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && !resp_last) |=> (busy || resp_valid))
        else $error("response cut short");

    // no word directly after the final one
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && resp_last) |=> !resp_valid)
        else $error("word after end of response");

endmodule

bind xcp_slave_command_handler xcsh_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req_last   (req_last),
    .resp_valid (resp_valid),
    .resp_count (resp_count),
    .resp_last  (resp_last)
);

`default_nettype wire

### bench/xcp_slave_command_handler_test.sv
// ----------------------------------------------------------------------------
// xcp_slave_command_handler_test
// Drives request packets byte by byte into the XCP slave command handler and
// checks every response word against a behavioral predictor of the command
// set, memory, transfer pointer and status registers.
// ----------------------------------------------------------------------------
`default_nettype none

module xcp_slave_command_handler_test;
    import xcsh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_BYTES = MEM_BYTES_DEF;
    localparam int IDLE_LIMIT = 200000;

    // identification text bytes
    localparam logic [7:0] ID_TEXT [12] = '{8'h44, 8'h45, 8'h4D, 8'h4F, 8'h5F, 8'h58,
                                           8'h43, 8'h50, 8'h5F, 8'h55, 8'h44, 8'h50};

    typedef struct packed {
        logic [7:0] b;
        logic       l;
    } req_item_t;

    typedef struct packed {
        logic [63:0] w;
        logic [3:0]  c;
        logic        l;
    } resp_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  req_byte = 8'h00;
    logic        req_last = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_SESSION_STATUS;
    logic [15:0] cfg_data = 16'h0000;
    logic        resp_valid;
    logic [63:0] resp_word;
    logic [3:0]  resp_count;
    logic        resp_last;

    // predictor state
    logic [7:0]  mem_model [MEM_BYTES];
    int          mta;
    logic [7:0]  hdr [8];
    logic [7:0]  dl_buf [255];
    int          rx_count;
    logic [7:0]  st_status;
    logic [7:0]  st_mask;
    logic [15:0] st_session;

    req_item_t   pending_bytes [$];
    resp_item_t  expected_words [$];
    int          errors = 0;
    int          gap = 0;
    bit          fresh = 0;
    bit          calm = 0;
    int          idle_cycles = 0;

    xcp_slave_command_handler i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_byte   (req_byte),
        .req_last   (req_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .resp_valid (resp_valid),
        .resp_word  (resp_word),
        .resp_count (resp_count),
        .resp_last  (resp_last)
    );

    always #6 clk = ~clk;

    // fold one request byte into the model, queue response words at packet end
    task automatic absorb_byte(input logic [7:0] b, input logic l);
        int pos;
        int len;
        int n;
        int rlen;
        int cnt;
        logic [31:0] a32;
        logic [7:0] rsp [256];
        logic [63:0] wd;
        resp_item_t it;
        pos = rx_count;
        if (pos < 8) hdr[pos] = b;
        if (pos >= 2 && pos < 257) dl_buf[pos - 2] = b;
        if (pos < 511) rx_count = pos + 1;
        if (!l) return;
        len = rx_count;
        rx_count = 0;
        for (int i = 0; i < 256; i++) rsp[i] = 8'h00;
        rsp[0] = PID_OK;
        rlen = 0;
        case (hdr[0])
            CMD_CONNECT:
            begin
                rsp[1] = 8'h04; rsp[2] = 8'h80; rsp[3] = 8'd32; rsp[4] = 8'd32;
                rsp[5] = 8'h00; rsp[6] = 8'h01; rsp[7] = 8'h01;
                rlen = 8;
            end
            CMD_GET_STATUS:
            begin
                rsp[1] = st_status; rsp[2] = st_mask;
                rsp[4] = st_session[7:0]; rsp[5] = st_session[15:8];
                rlen = 8;
            end
            CMD_GET_ID:
            begin
                rsp[2] = 8'd12;
                for (int i = 0; i < 12; i++) rsp[3 + i] = ID_TEXT[i];
                rlen = 15;
            end
            CMD_SET_MTA:
            begin
                if (len >= 6)
                begin
                    a32 = {hdr[5], hdr[4], hdr[3], hdr[2]};
                    if (a32 >= MEM_BYTES) a32 = MEM_BYTES - 1;
                    mta = int'(a32);
                    rlen = 1;
                end
            end
            CMD_UPLOAD:
            begin
                if (len >= 2)
                begin
                    n = hdr[1];
                    if (n == 0) n = 1;
                    if (mta + n > MEM_BYTES) n = MEM_BYTES - mta;
                    for (int i = 0; i < n; i++) rsp[1 + i] = mem_model[mta + i];
                    mta += n;
                    rlen = 1 + n;
                end
            end
            CMD_SHORT_UPLOAD:
            begin
                if (len >= 8)
                begin
                    n = hdr[1];
                    a32 = {hdr[7], hdr[6], hdr[5], hdr[4]};
                    if (a32 >= MEM_BYTES) a32 = MEM_BYTES - 1;
                    if (int'(a32) + n > MEM_BYTES) n = MEM_BYTES - int'(a32);
                    for (int i = 0; i < n; i++) rsp[1 + i] = mem_model[int'(a32) + i];
                    rlen = 1 + n;
                end
            end
            CMD_DOWNLOAD:
            begin
                if (len >= 2 && len >= 2 + hdr[1])
                begin
                    n = hdr[1];
                    if (mta + n > MEM_BYTES) n = MEM_BYTES - mta;
                    for (int i = 0; i < n && i < 255; i++) mem_model[mta + i] = dl_buf[i];
                    mta += n;
                    rlen = 1;
                end
            end
            CMD_DISCONNECT, CMD_SYNCH:
            begin
                rlen = 1;
            end
            default:
            begin
                rlen = 0;
            end
        endcase
        if (rlen == 0)
        begin
            rsp[0] = PID_ERR;
            rsp[1] = ERR_SYNTAX;
            rlen = 2;
        end
        // pack eight bytes to a word, first byte lowest
        for (int w = 0; w * 8 < rlen; w++)
        begin
            cnt = rlen - w * 8;
            if (cnt > 8) cnt = 8;
            wd = '0;
            for (int k = 0; k < cnt; k++) wd[8 * k +: 8] = rsp[w * 8 + k];
            it.w = wd;
            it.c = cnt[3:0];
            it.l = (w * 8 + 8 >= rlen);
            expected_words.push_back(it);
        end
    endtask

    // gap before the next request byte: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (fresh)
        begin
            fresh = 0;
            gap = pick_gap();
        end
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (gap > 0)
        begin
            gap--;
            start <= 1'b0;
        end
        else if (pending_bytes.size() > 0)
        begin
            start <= 1'b1;
            req_byte <= pending_bytes[0].b;
            req_last <= pending_bytes[0].l;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // monitor: accept words, update model, check responses
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SESSION_STATUS:  st_status = cfg_data[7:0];
                    CFG_PROTECTION_MASK: st_mask = cfg_data[7:0];
                    CFG_SESSION_NUMBER:  st_session = cfg_data;
                    default:             ;
                endcase
            end
            if (resp_valid)
            begin
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%t unexpected response word %h count %0d last %0b",
                             $realtime, resp_word, resp_count, resp_last);
                end
                else
                begin
                    resp_item_t e;
                    e = expected_words.pop_front();
                    if (resp_word !== e.w)
                    begin
                        errors++;
                        $display("%t resp_word expected %h actual %h", $realtime, e.w, resp_word);
                    end
                    if (resp_count !== e.c)
                    begin
                        errors++;
                        $display("%t resp_count expected %0d actual %0d",
                                 $realtime, e.c, resp_count);
                    end
                    if (resp_last !== e.l)
                    begin
                        errors++;
                        $display("%t resp_last expected %0b actual %0b",
                                 $realtime, e.l, resp_last);
                    end
                end
            end
            if (start && !busy)
            begin
                absorb_byte(req_byte, req_last);
                void'(pending_bytes.pop_front());
                fresh = 1;
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk)
    begin
        if ((start && !busy) || resp_valid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("xcp_slave_command_handler_test NOT OK");
            $finish;
        end
    end

    task automatic queue_packet(input logic [7:0] p [$]);
        req_item_t it;
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < p.size(); i++)
        begin
            it.b = p[i];
            it.l = (i == p.size() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_1000;
            1:       return 32'h0000_FF00 + $urandom_range(0, 255);
            2:       return $urandom;
            3:       return 32'h0001_0000;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [7:0] pick_count();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 12));
    endfunction

    // one random packet, mostly well formed
    task automatic queue_random_packet();
        logic [7:0] p [$];
        logic [7:0] cmds [9];
        logic [31:0] a;
        int n;
        cmds = '{CMD_CONNECT, CMD_DISCONNECT, CMD_GET_STATUS, CMD_SYNCH, CMD_GET_ID,
                 CMD_SET_MTA, CMD_UPLOAD, CMD_SHORT_UPLOAD, CMD_DOWNLOAD};
        case ($urandom_range(0, 11))
            0, 1:
            begin
                p.push_back(cmds[$urandom_range(0, 4)]);
                repeat ($urandom_range(0, 2)) p.push_back(8'($urandom));
            end
            2, 3:
            begin
                a = pick_addr();
                p = '{CMD_SET_MTA, 8'($urandom), a[7:0], a[15:8], a[23:16], a[31:24]};
                if ($urandom_range(0, 3) == 0) p.push_back(8'($urandom));
            end
            4, 5:
            begin
                p = '{CMD_UPLOAD, pick_count()};
            end
            6:
            begin
                a = pick_addr();
                p = '{CMD_SHORT_UPLOAD, pick_count(), 8'($urandom), 8'($urandom),
                      a[7:0], a[15:8], a[23:16], a[31:24]};
            end
            7, 8:
            begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
                p = '{CMD_DOWNLOAD, n[7:0]};
                repeat (n) p.push_back(8'($urandom));
                if ($urandom_range(0, 3) == 0) p.push_back(8'($urandom));
                // drop the last byte: too short for its count unless a spare byte was added
                if (n > 0 && $urandom_range(0, 5) == 0)
                    void'(p.pop_back());
            end
            9:
            begin
                p.push_back(cmds[$urandom_range(5, 8)]);
                repeat ($urandom_range(0, 4)) p.push_back(8'($urandom));
            end
            10:
            begin
                repeat ($urandom_range(1, 10)) p.push_back(8'($urandom));
            end
            default:
            begin
                // oversized packet now and then, else noise
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(258, 300) : $urandom_range(1, 6);
                repeat (n) p.push_back(8'($urandom));
            end
        endcase
        queue_packet(p);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || expected_words.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        for (int i = 0; i < MEM_BYTES; i++) mem_model[i] = i[7:0];
        mem_model[16'h1000] = 8'h11;
        mem_model[16'h1001] = 8'h22;
        mem_model[16'h1002] = 8'h33;
        mem_model[16'h1003] = 8'h44;
        mta = 0;
        rx_count = 0;
        for (int i = 0; i < 8; i++) hdr[i] = 8'h00;
        st_status = 8'h00;
        st_mask = 8'h00;
        st_session = 16'h0001;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            // configuration while idle, extremes first
            case (phase)
                0:
                begin
                    write_reg(CFG_SESSION_STATUS, 16'h0000);
                    write_reg(CFG_PROTECTION_MASK, 16'h0000);
                    write_reg(CFG_SESSION_NUMBER, 16'h0000);
                end
                1:
                begin
                    write_reg(CFG_SESSION_STATUS, 16'h00FF);
                    write_reg(CFG_PROTECTION_MASK, 16'h00FF);
                    write_reg(CFG_SESSION_NUMBER, 16'hFFFF);
                end
                default:
                begin
                    write_reg(CFG_SESSION_STATUS, 16'($urandom_range(0, 255)));
                    write_reg(CFG_PROTECTION_MASK, 16'($urandom_range(0, 255)));
                    write_reg(CFG_SESSION_NUMBER, 16'($urandom_range(0, 65535)));
                end
            endcase
            sent = 0;
            if (phase == 0)
            begin
                // every command but SHORT_UPLOAD and DOWNLOAD, errors, demo pattern readback
                queue_packet('{CMD_CONNECT});
                queue_packet('{CMD_GET_STATUS});
                queue_packet('{CMD_GET_ID});
                queue_packet('{CMD_DISCONNECT});
                queue_packet('{CMD_SYNCH});
                queue_packet('{8'h00});
                queue_packet('{CMD_SET_MTA, 8'h00, 8'h00});
                queue_packet('{CMD_UPLOAD});
                queue_packet('{CMD_SET_MTA, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00});
                queue_packet('{CMD_UPLOAD, 8'h04});
                queue_packet('{CMD_UPLOAD, 8'h00});
            end
            else
            begin
                queue_packet('{CMD_GET_STATUS});
            end
            // pointer clamped to the last byte reads it, then at memory end moves nothing
            if (phase == 1)
            begin
                queue_packet('{CMD_SET_MTA, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
                queue_packet('{CMD_UPLOAD, 8'hFF});
                queue_packet('{CMD_UPLOAD, 8'h01});
                queue_packet('{CMD_DOWNLOAD, 8'h01, 8'hA5});
            end
            sent = pending_bytes.size();
            while (sent < 105)
            begin
                int before_n;
                before_n = pending_bytes.size();
                queue_random_packet();
                sent += pending_bytes.size() - before_n;
            end
            wait_drained();
        end

        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("xcp_slave_command_handler_test OK");
        else
            $display("xcp_slave_command_handler_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
